[src/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and CRC fold functions
// Payload structs, configuration register indexes and the byte-wise CRC
// update functions for the multi-mode CRC engine.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int CRC_W = 32;
  localparam int CRC16_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT = 4'd1;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_CRC32 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CCITT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_R8408 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MODBUS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_M8005 = 3'd4;

  localparam logic [CRC_W-1:0] POLY32_REFL = 32'hEDB8_8320;
  localparam logic [CRC16_W-1:0] POLY_CCITT = 16'h1021;
  localparam logic [CRC16_W-1:0] POLY_8408 = 16'h8408;
  localparam logic [CRC16_W-1:0] POLY_MODBUS = 16'hA001;
  localparam logic [CRC16_W-1:0] POLY_8005 = 16'h8005;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        final_res;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CRC_W-1:0]  init_value;
  } cfg_t;

  function automatic logic [CRC_W-1:0] fold_refl32(input logic [CRC_W-1:0] c_in,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? POLY32_REFL : '0);
    end
    return c;
  endfunction

  function automatic logic [CRC16_W-1:0] fold_refl16(input logic [CRC16_W-1:0] c_in,
                                                    input logic [7:0] b,
                                                    input logic [CRC16_W-1:0] poly);
    logic [CRC16_W-1:0] c;
    c = c_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? poly : '0);
    end
    return c;
  endfunction

  function automatic logic [CRC16_W-1:0] fold_msb16(input logic [CRC16_W-1:0] c_in,
                                                   input logic [7:0] b,
                                                   input logic [CRC16_W-1:0] poly);
    logic [CRC16_W-1:0] c;
    c = c_in ^ {b, 8'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC16_W-1] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

[src/mcc_cfg.sv]
// ----------------------------------------------------------------------------
// mcc_cfg: configuration registers
// Holds the mode and init value, written through the cfg write channel.
// ----------------------------------------------------------------------------
module mcc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mcc_pkg::cfg_t                  cfg_o
);
  import mcc_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CRC_W-1:0]  init_r, init_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    init_nxt = init_r;
    if (cfg_valid) begin
      // indexes beyond the register list are dropped
      if (cfg_index == REG_MODE) begin
        mode_nxt = cfg_wdata[MODE_W-1:0];
      end else if (cfg_index == REG_INIT) begin
        init_nxt = cfg_wdata[CRC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      init_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      init_r <= init_nxt;
    end
  end

  assign cfg_o.mode = mode_r;
  assign cfg_o.init_value = init_r;

endmodule

[src/mcc_fold.sv]
// ----------------------------------------------------------------------------
// mcc_fold: byte-wise CRC update
// Folds one byte into the running CRC for the selected mode and forms the
// reported value.
// ----------------------------------------------------------------------------
module mcc_fold (
  input  mcc_pkg::cfg_t              cfg_i,
  input  logic [mcc_pkg::CRC_W-1:0]  crc_i,
  input  mcc_pkg::in_item_t          item_i,
  output logic [mcc_pkg::CRC_W-1:0]  crc_o,
  output mcc_pkg::out_item_t         res_o
);
  import mcc_pkg::*;

  logic [CRC_W-1:0]   base;
  logic [CRC_W-1:0]   c32;
  logic [CRC16_W-1:0] c16;

  // reload from init before folding when the byte opens a message
  assign base = item_i.start_req ? cfg_i.init_value : crc_i;

  always_comb begin
    c32 = '0;
    c16 = '0;
    crc_o = base;
    res_o.crc_value = '0;
    res_o.final_res = item_i.last;
    unique case (cfg_i.mode)
      MODE_CRC32: begin
        c32 = fold_refl32(base, item_i.data_byte);
        crc_o = c32;
        res_o.crc_value = ~c32;
      end
      MODE_CCITT: begin
        c16 = fold_msb16(base[CRC16_W-1:0], item_i.data_byte, POLY_CCITT);
      end
      MODE_R8408: begin
        c16 = fold_refl16(base[CRC16_W-1:0], item_i.data_byte, POLY_8408);
      end
      MODE_MODBUS: begin
        c16 = fold_refl16(base[CRC16_W-1:0], item_i.data_byte, POLY_MODBUS);
      end
      MODE_M8005: begin
        c16 = fold_msb16(base[CRC16_W-1:0], item_i.data_byte, POLY_8005);
      end
      default: begin
        // unused mode: hold the (possibly reloaded) register, report zero
      end
    endcase
    if (cfg_i.mode != MODE_CRC32 && cfg_i.mode <= MODE_M8005) begin
      crc_o = {16'd0, c16};
      res_o.crc_value = {16'd0, c16};
    end
  end

endmodule

[src/multi_mode_crc_engine.sv]
// ----------------------------------------------------------------------------
// multi_mode_crc_engine: five-mode byte-serial CRC engine
// Path: an accepted byte is registered in the input stage, then folded into
// the result register, where out_valid rises.
// Throughput: one byte per cycle while out_ready does not stall the result
// register, set by the combinational byte fold into the running CRC register.
// Reset: synchronous rst_n clears both pipeline valids, the CRC register
// and the configuration (mode 0, init value 0); no clearing pass.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mcc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mcc_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mcc_pkg::*;

  cfg_t       cfg;
  in_item_t   s1_item_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic [CRC_W-1:0] crc_reg_r, crc_reg_nxt;
  logic [CRC_W-1:0] fold_crc;
  out_item_t  fold_res;
  logic       s1_adv;
  logic       in_acc;

  mcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  mcc_fold u_fold (
    .cfg_i  (cfg),
    .crc_i  (crc_reg_r),
    .item_i (s1_item_r),
    .crc_o  (fold_crc),
    .res_o  (fold_res)
  );

  // advance the input stage whenever the result register is free or draining
  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
    crc_reg_nxt = s1_adv ? fold_crc : crc_reg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_reg_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_reg_r   <= crc_reg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= fold_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_item_r;

`ifndef SYNTHESIS
  // a stalled input stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input stage dropped a stalled transaction");

  // the running CRC moves only when a byte is folded
  a_crc_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !s1_adv |=> $stable(crc_reg_r))
    else $error("crc register changed without a folded byte");

  // 16-bit modes keep the upper half of the register clear
  a_crc16_mask: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_adv && (cfg.mode == MODE_CCITT || cfg.mode == MODE_R8408 ||
                        cfg.mode == MODE_MODBUS || cfg.mode == MODE_M8005)
    |=> crc_reg_r[CRC_W-1:CRC16_W] == '0)
    else $error("16-bit mode left upper crc bits set");

  // a new result appears only from an advancing input stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result valid without a folded transaction");
`endif

endmodule

[tb/multi_mode_crc_engine_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_mode_crc_engine_test: self-checking bench for the multi-mode CRC engine
// Drives byte transactions with random gaps and result back-pressure, writes
// mode and init registers between bursts, and checks every result against a
// bit-serial CRC predictor kept in step with each accepted byte.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine_test;
  import mcc_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 6;
  localparam int PIPE_LAT = 2;
  localparam int MAX_IDLE = 6;
  localparam int RANDOM_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MODE_MAX = (1 << MODE_W) - 1;
  localparam int IDX_MAX = (1 << CFG_IDX_W) - 1;

  localparam logic [31:0] GEN_CRC32_R = 32'hEDB8_8320;
  localparam logic [15:0] GEN_CCITT = 16'h1021;
  localparam logic [15:0] GEN_X25_R = 16'h8408;
  localparam logic [15:0] GEN_MODBUS_R = 16'hA001;
  localparam logic [15:0] GEN_ARC = 16'h8005;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [MODE_W-1:0] cur_mode;
  logic [31:0] cur_init;
  logic [31:0] crc_state;
  out_item_t crc_results_q[$];

  bit no_idle;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned cfg_writes;
  int unsigned errors;

  multi_mode_crc_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [31:0] shift_lsb_first(logic [31:0] c, logic [7:0] b,
                                                  logic [31:0] poly);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] shift_msb_first16(logic [15:0] c, logic [7:0] b,
                                                    logic [15:0] poly);
    logic [15:0] r;
    r = c ^ {b, 8'd0};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  // advance the running CRC by one byte and return the result it reports
  function automatic out_item_t crc_after_byte(in_item_t it);
    out_item_t r;
    if (it.start_req) crc_state = cur_init;
    r.final_res = it.last;
    r.crc_value = '0;
    case (cur_mode)
      MODE_CRC32: begin
        crc_state = shift_lsb_first(crc_state, it.data_byte, GEN_CRC32_R);
        r.crc_value = ~crc_state;
      end
      MODE_CCITT: begin
        crc_state = {16'd0, shift_msb_first16(crc_state[15:0], it.data_byte, GEN_CCITT)};
        r.crc_value = crc_state;
      end
      MODE_R8408: begin
        crc_state = shift_lsb_first({16'd0, crc_state[15:0]}, it.data_byte,
                                    {16'd0, GEN_X25_R});
        r.crc_value = crc_state;
      end
      MODE_MODBUS: begin
        crc_state = shift_lsb_first({16'd0, crc_state[15:0]}, it.data_byte,
                                    {16'd0, GEN_MODBUS_R});
        r.crc_value = crc_state;
      end
      MODE_M8005: begin
        crc_state = {16'd0, shift_msb_first16(crc_state[15:0], it.data_byte, GEN_ARC)};
        r.crc_value = crc_state;
      end
      default: begin
        // spare modes: hold the register, report zero
      end
    endcase
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input logic l);
    int gap;
    in_item_t it;
    it.data_byte = b;
    it.start_req = s;
    it.last = l;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    crc_results_q.push_back(crc_after_byte(it));
    items_sent++;
  endtask

  // hold off the sender until every pending result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (crc_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MODE) cur_mode = val[MODE_W-1:0];
    else if (idx == REG_INIT) cur_init = val;
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_mode_word();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 6) == 0)
      v[MODE_W-1:0] = MODE_W'($urandom_range(int'(MODE_M8005) + 1, MODE_MAX));
    else
      v[MODE_W-1:0] = MODE_W'($urandom_range(int'(MODE_CRC32), int'(MODE_M8005)));
    return v;
  endfunction

  function automatic logic [31:0] pick_init();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {16'd0, 16'hFFFF};
      default: return $urandom();
    endcase
  endfunction

  // result side: random back-pressure, check each transaction in order
  initial begin : result_sink
    int stall;
    out_item_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_checked++;
      if (crc_results_q.size() == 0) begin
        $error("result with nothing pending: crc_value %h final_res %b",
               out_data.crc_value, out_data.final_res);
        errors++;
      end else begin
        want = crc_results_q.pop_front();
        if (out_data.crc_value !== want.crc_value) begin
          $error("crc_value: expected %h, got %h", want.crc_value, out_data.crc_value);
          errors++;
        end
        if (out_data.final_res !== want.final_res) begin
          $error("final_res: expected %b, got %b", want.final_res, out_data.final_res);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[multi_mode_crc_engine] ERROR");
    $finish;
  end

  task automatic test_reset_defaults();
    // registers come up as CRC-32 with zero init
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_each_mode();
    for (int m = int'(MODE_CRC32); m <= int'(MODE_M8005); m++) begin
      write_reg(REG_MODE, 32'(m));
      write_reg(REG_INIT, (m % 2 == 0) ? '1 : '0);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      wait_results_drained();
    end
  endtask

  task automatic test_spare_modes();
    write_reg(REG_INIT, 32'hA5C3_5A3C);
    for (int m = int'(MODE_M8005) + 1; m <= MODE_MAX; m++) begin
      write_reg(REG_MODE, 32'hFFFF_FFF8 | 32'(m));
      send_byte(8'h5A, 1'b1, 1'b1);
      wait_results_drained();
    end
    // the reloaded register is kept and folded on return to a live mode
    write_reg(REG_MODE, 32'(MODE_CRC32));
    send_byte(8'h81, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_mode_switch_mid_message();
    write_reg(REG_INIT, '1);
    write_reg(REG_MODE, 32'(MODE_CRC32));
    send_byte(8'h31, 1'b1, 1'b0);
    wait_results_drained();
    write_reg(REG_MODE, 32'(MODE_CCITT));
    send_byte(8'h32, 1'b0, 1'b0);
    wait_results_drained();
    write_reg(REG_MODE, 32'(MODE_CRC32));
    send_byte(8'h33, 1'b0, 1'b1);
    // last does not clear: keep folding without start
    send_byte(8'h34, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_bad_reg_index();
    for (int i = int'(REG_INIT) + 1; i <= IDX_MAX; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom());
    end
    send_byte(8'hC3, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned target);
    int unsigned base;
    int unsigned len;
    bit carry_on;
    logic s;
    logic l;
    base = items_sent;
    while (items_sent - base < target) begin
      wait_results_drained();
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_MODE, pick_mode_word());
      if ($urandom_range(0, 2) != 0) write_reg(REG_INIT, pick_init());
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_INIT) + 1, IDX_MAX)), $urandom());
      // sometimes continue the previous message across the register change
      carry_on = ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          s = (i == 0) && !carry_on;
          l = (i == len - 1);
          if ($urandom_range(0, 9) == 0) begin
            s = 1'($urandom_range(0, 1));
            l = 1'($urandom_range(0, 1));
          end
          send_byte(8'($urandom_range(0, 255)), s, l);
        end
        carry_on = 1'b0;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cur_mode = MODE_CRC32;
    cur_init = '0;
    crc_state = '0;
    no_idle = 1'b0;
    items_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    errors = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_each_mode();
    test_spare_modes();
    test_mode_switch_mid_message();
    test_bad_reg_index();
    test_random_traffic(RANDOM_ITEMS);

    wait_results_drained();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (crc_results_q.size() != 0) begin
      $error("%0d results never arrived", crc_results_q.size());
      errors++;
    end
    $display("covered all five CRC modes, spare modes, mid-message mode changes and bad indexes");
    $display("%0d bytes sent, %0d results checked, %0d register writes, %0d errors",
             items_sent, results_checked, cfg_writes, errors);
    if (errors == 0) begin
      $display("[multi_mode_crc_engine] OK");
    end else begin
      $display("[multi_mode_crc_engine] ERROR");
    end
    $finish;
  end

endmodule
